>>> rtl/line_break_splitter_assert.svh
// Assertion macros for the line break splitter RTL.
// Included by the modules that check their own logic; needs no other file.
`ifndef LINE_BREAK_SPLITTER_ASSERT_SVH
`define LINE_BREAK_SPLITTER_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define LBS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition in one cycle leads to a consequence in the next.
`define LBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LBS_ASSERT(lbl, clk, rst_n, prop, msg)
`define LBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/lbs_pkg.sv
// Shared types and constants of the line break splitter.
// No dependencies; every other RTL file but the assertion header imports it.
package lbs_pkg;

    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_BREAK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_BREAK = 2'd1;

    // Warning codes
    localparam logic [1:0] WARN_NONE  = 2'd0;
    localparam logic [1:0] WARN_STRAY = 2'd1;
    localparam logic [1:0] WARN_WRONG = 2'd2;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] out_byte;
        logic [1:0]        warning;
        logic              last;
    } result_t;

    // One queued request: the results caused by one input byte
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

>>> rtl/lbs_if.sv
// Channel interfaces of the line break splitter: bytes, results, configuration.
// Depends on lbs_pkg.
interface lbs_byte_if;
    import lbs_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface lbs_result_if;
    import lbs_pkg::*;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [BYTE_W-1:0] out_byte;
    logic [1:0]        warning;
    logic              last;
    modport source (output valid, output kind, output out_byte, output warning,
                    output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input warning,
                    input last, output ready);
endinterface

interface lbs_cfg_if;
    import lbs_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/lbs_front.sv
// Front end: accepts bytes, tracks the terminator state and forms requests.
// Depends on lbs_pkg and lbs_if.
module lbs_front (
    input  logic           clk,
    input  logic           rst_n,
    lbs_cfg_if.sink        cfg,
    lbs_byte_if.sink       bytes,
    input  lbs_pkg::q_stat_t q_stat,
    output logic           push_valid,
    output lbs_pkg::cmd_t  push_cmd
);
    import lbs_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] term_one;
        logic [BYTE_W-1:0] term_two;
        logic              seen;
        logic              learning;
    } st_t;

    typedef struct packed {
        st_t        st;
        logic       emit;
        logic       eol;
        logic [1:0] warn;
        logic       again;
    } pass_t;

    st_t   st_reg, st_next;
    pass_t p1, p2;
    logic  acc;

    function automatic logic is_crlf(logic [BYTE_W-1:0] c);
        return (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic pass_t one_pass(st_t s, logic [BYTE_W-1:0] c);
        pass_t p;
        p.st    = s;
        p.emit  = 1'b0;
        p.eol   = 1'b0;
        p.warn  = WARN_NONE;
        p.again = 1'b0;
        if (s.seen)
        begin
            p.st.seen = 1'b0;
            p.emit    = 1'b1;
            p.eol     = 1'b1;
            if (s.learning)
            begin
                p.st.learning = 1'b0;
                if ((c != s.term_one) && is_crlf(c))
                    p.st.term_two = c;
                else
                    p.again = 1'b1;
            end
            else if (c != s.term_two)
            begin
                p.again = 1'b1;
                p.warn  = WARN_WRONG;
            end
        end
        else if (s.term_one != '0)
        begin
            if (c == s.term_one)
            begin
                if (s.term_two != '0)
                begin
                    p.st.seen     = 1'b1;
                    p.st.learning = 1'b0;
                end
                else
                begin
                    p.emit = 1'b1;
                    p.eol  = 1'b1;
                end
            end
            else
            begin
                p.emit = 1'b1;
                p.eol  = is_crlf(c);
                p.warn = is_crlf(c) ? WARN_STRAY : WARN_NONE;
            end
        end
        else if (is_crlf(c))
        begin
            // learn the first terminator
            p.st.term_one = c;
            p.st.seen     = 1'b1;
            p.st.learning = 1'b1;
        end
        else
        begin
            p.emit = 1'b1;
        end
        return p;
    endfunction

    function automatic result_t make_res(pass_t p, logic [BYTE_W-1:0] c, logic lst);
        result_t r;
        r.kind     = p.eol;
        r.out_byte = p.eol ? '0 : c;
        r.warning  = p.warn;
        r.last     = lst;
        return r;
    endfunction

    assign cfg.ready   = 1'b1;
    assign bytes.ready = !q_stat.full;
    assign acc         = bytes.valid && !q_stat.full;

    always_comb
    begin
        p1 = one_pass(st_reg, bytes.in_byte);
        p2 = one_pass(p1.st, bytes.in_byte);
        push_cmd.two = p1.again && p2.emit;
        push_cmd.r0  = make_res(p1, bytes.in_byte, !(p1.again && p2.emit));
        push_cmd.r1  = make_res(p2, bytes.in_byte, 1'b1);
        push_valid   = acc && p1.emit;

        st_next = st_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_FIRST_BREAK:
                begin
                    st_next.term_one = cfg.data;
                    st_next.seen     = 1'b0;
                    st_next.learning = 1'b0;
                end
                REG_SECOND_BREAK:
                begin
                    st_next.term_two = cfg.data;
                    st_next.seen     = 1'b0;
                    st_next.learning = 1'b0;
                end
                default:
                begin
                    st_next = st_reg;
                end
            endcase
        end
        else if (acc)
        begin
            st_next = p1.again ? p2.st : p1.st;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else
            st_reg <= st_next;
    end

endmodule

>>> rtl/lbs_queue.sv
// Request queue between front and back end of the line break splitter.
// Depends on lbs_pkg and line_break_splitter_assert.svh.
module lbs_queue #(
    parameter int DEPTH = lbs_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  lbs_pkg::cmd_t    push_cmd,
    input  logic             pop,
    output lbs_pkg::cmd_t    pop_cmd,
    output lbs_pkg::q_stat_t q_stat
);
    import lbs_pkg::*;
`include "line_break_splitter_assert.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign q_stat.full  = (cnt_reg == CNT_FULL);
    assign q_stat.empty = (cnt_reg == '0);
    assign pop_cmd      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push_valid)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push_valid && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push_valid)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    `LBS_ASSERT(a_no_push_full, clk, rst_n, !(push_valid && q_stat.full), "push into full queue")
    `LBS_ASSERT(a_no_pop_empty, clk, rst_n, !(pop && q_stat.empty), "pop from empty queue")

endmodule

>>> rtl/lbs_back.sv
// Back end: drains requests and hands out one result per cycle while the receiver takes them.
// Depends on lbs_pkg, lbs_if and line_break_splitter_assert.svh.
module lbs_back (
    input  logic             clk,
    input  logic             rst_n,
    input  lbs_pkg::q_stat_t q_stat,
    input  lbs_pkg::cmd_t    pop_cmd,
    output logic             pop,
    lbs_result_if.source     results
);
    import lbs_pkg::*;
`include "line_break_splitter_assert.svh"

    logic    out_valid_reg, out_valid_next;
    logic    sec_valid_reg, sec_valid_next;
    result_t out_res_reg, out_res_next;
    result_t sec_res_reg, sec_res_next;
    logic    slot_free;

    assign slot_free = !out_valid_reg || results.ready;
    assign pop       = slot_free && !sec_valid_reg && !q_stat.empty;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        sec_valid_next = sec_valid_reg;
        out_res_next   = out_res_reg;
        sec_res_next   = sec_res_reg;
        if (slot_free)
        begin
            priority if (sec_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_res_next   = sec_res_reg;
                sec_valid_next = 1'b0;
            end
            else if (!q_stat.empty)
            begin
                out_valid_next = 1'b1;
                out_res_next   = pop_cmd.r0;
                sec_valid_next = pop_cmd.two;
                sec_res_next   = pop_cmd.r1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sec_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sec_valid_reg <= sec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
        sec_res_reg <= sec_res_next;
    end

    assign results.valid    = out_valid_reg;
    assign results.kind     = out_res_reg.kind;
    assign results.out_byte = out_res_reg.out_byte;
    assign results.warning  = out_res_reg.warning;
    assign results.last     = out_res_reg.last;

    `LBS_ASSERT(a_sec_behind_out, clk, rst_n, !sec_valid_reg || out_valid_reg, "second result without first")
    `LBS_ASSERT(a_first_not_last, clk, rst_n, !(sec_valid_reg && out_res_reg.last), "first of pair marked last")
    `LBS_ASSERT_NEXT(a_pop_shows, clk, rst_n, pop, out_valid_reg, "popped request not shown")

endmodule

>>> rtl/line_break_splitter.sv
// Top level of the line break splitter: front end, request queue, back end.
// Depends on lbs_pkg, lbs_if, lbs_front, lbs_queue and lbs_back.
//
//   channel   role    payload                          accepted when
//   cfg       sink    index, data                      valid && ready
//   bytes     sink    in_byte                          valid && ready
//   results   source  kind, out_byte, warning, last    valid && ready
//
// When a byte is taken, the front end resolves the terminator state for it at once,
// including the re-examination of a byte that ended a line. The back end hands out
// one result per cycle while the receiver takes them; the first result of a byte
// passes through the queue entry and then the results register.
// The front end stalls only when the request queue (QUEUE_DEPTH entries) is full; the
// back end pops when the results register is free or taken and no second result waits.
// Reset clears the terminators to zero (learning mode), the queue and the valid flag of
// the results register. Configuration writes are always taken.
module line_break_splitter #(
    parameter int QUEUE_DEPTH = lbs_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    lbs_cfg_if.sink      cfg,
    lbs_byte_if.sink     bytes,
    lbs_result_if.source results
);
    import lbs_pkg::*;

    // request path from front to queue
    logic    push_valid;
    cmd_t    push_cmd;
    // request path from queue to back
    cmd_t    pop_cmd;
    logic    pop;
    q_stat_t q_stat;

    // Classify each byte and form its request
    lbs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .bytes      (bytes),
        .q_stat     (q_stat),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    // Hold requests so either side may stall on its own
    lbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .pop_cmd    (pop_cmd),
        .q_stat     (q_stat)
    );

    // Drain requests into the results channel
    lbs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_stat  (q_stat),
        .pop_cmd (pop_cmd),
        .pop     (pop),
        .results (results)
    );

endmodule

>>> tb/lbs_split_checker.sv
// Line splitter checker: predicts the results of each byte request and compares them.
// Depends on lbs_pkg and the channel interfaces in lbs_if.
module lbs_split_checker (
    input  logic   clk,
    input  logic   rst_n,
    lbs_cfg_if     cfg,
    lbs_byte_if    bytes,
    lbs_result_if  results,
    output int     fail_count,
    output int     pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import lbs_pkg::*;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_EOL  = 1'b1;
    localparam int   PRINT_CAP = 50;

    // Predicted line state
    logic [BYTE_W-1:0] lead_char;
    logic [BYTE_W-1:0] tail_char;
    logic              lead_seen;
    logic              probing;

    result_t expected_lines[$];
    int      mismatches = 0;
    int      pending_n;

    assign fail_count = mismatches;
    assign pending    = pending_n;

    function automatic logic is_line_char(input logic [BYTE_W-1:0] c);
        return (c == CH_CR) || (c == CH_LF);
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] mismatch %s: expected %0h got %0h", $realtime, what, want, got);
    endtask

    // One look at a byte; may ask for the byte to be looked at again
    task automatic split_pass(input logic [BYTE_W-1:0] c, output logic produced,
                              output result_t r, output logic rerun);
        r = '{kind: KIND_EOL, out_byte: '0, warning: WARN_NONE, last: 1'b0};
        produced = 1'b1;
        rerun    = 1'b0;
        if (lead_seen) begin
            lead_seen = 1'b0;
            if (probing) begin
                probing = 1'b0;
                if (c != lead_char && is_line_char(c))
                    tail_char = c;
                else
                    rerun = 1'b1;
            end
            else if (c != tail_char) begin
                rerun     = 1'b1;
                r.warning = WARN_WRONG;
            end
        end
        else if (lead_char != '0 && tail_char != '0) begin
            if (c == lead_char) begin
                lead_seen = 1'b1;
                probing   = 1'b0;
                produced  = 1'b0;
            end
            else if (is_line_char(c))
                r.warning = WARN_STRAY;
            else begin
                r.kind     = KIND_BYTE;
                r.out_byte = c;
            end
        end
        else if (lead_char != '0) begin
            if (c != lead_char) begin
                if (is_line_char(c))
                    r.warning = WARN_STRAY;
                else begin
                    r.kind     = KIND_BYTE;
                    r.out_byte = c;
                end
            end
        end
        else if (is_line_char(c)) begin
            lead_char = c;
            lead_seen = 1'b1;
            probing   = 1'b1;
            produced  = 1'b0;
        end
        else begin
            r.kind     = KIND_BYTE;
            r.out_byte = c;
        end
    endtask

    task automatic predict_byte(input logic [BYTE_W-1:0] c);
        result_t r0;
        result_t r1;
        logic    m0;
        logic    m1;
        logic    a0;
        logic    a1;
        m1 = 1'b0;
        split_pass(c, m0, r0, a0);
        if (a0)
            split_pass(c, m1, r1, a1);
        if (m1)
            r1.last = 1'b1;
        else if (m0)
            r0.last = 1'b1;
        if (m0)
            expected_lines.push_back(r0);
        if (m1)
            expected_lines.push_back(r1);
    endtask

    task automatic compare_result(input result_t got);
        result_t want;
        if (expected_lines.size() == 0) begin
            report_mismatch("result with nothing expected", 0, got);
            return;
        end
        want = expected_lines.pop_front();
        if (got.kind != want.kind)
            report_mismatch("kind", want.kind, got.kind);
        if (got.out_byte != want.out_byte)
            report_mismatch("out_byte", want.out_byte, got.out_byte);
        if (got.warning != want.warning)
            report_mismatch("warning", want.warning, got.warning);
        if (got.last != want.last)
            report_mismatch("last", want.last, got.last);
    endtask

    always @(posedge clk or negedge rst_n) begin : track
        result_t got;
        if (!rst_n) begin
            lead_char = '0;
            tail_char = '0;
            lead_seen = 1'b0;
            probing   = 1'b0;
            expected_lines.delete();
            pending_n <= 0;
        end
        else begin
            if (cfg.valid && cfg.ready) begin
                if (cfg.index == REG_FIRST_BREAK) begin
                    lead_char = cfg.data;
                    lead_seen = 1'b0;
                    probing   = 1'b0;
                end
                else if (cfg.index == REG_SECOND_BREAK) begin
                    tail_char = cfg.data;
                    lead_seen = 1'b0;
                    probing   = 1'b0;
                end
            end
            if (bytes.valid && bytes.ready)
                predict_byte(bytes.in_byte);
            if (results.valid && results.ready) begin
                got = '{kind: results.kind, out_byte: results.out_byte,
                        warning: results.warning, last: results.last};
                compare_result(got);
            end
            pending_n <= expected_lines.size();
        end
    end

endmodule

>>> tb/tb_line_break_splitter.sv
// Testbench top of the line break splitter: clock, reset, stimulus and verdict.
// Depends on lbs_pkg, lbs_if, lbs_split_checker and the line_break_splitter RTL.
module tb_line_break_splitter;
    timeunit 1ns;
    timeprecision 1ps;
    import lbs_pkg::*;

    // Indexes past the register list; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    localparam int RESET_CYCLES   = 7;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTINGS_N     = 11;
    localparam int BYTES_PER_SET  = 100;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int fail_count;
    int pending;

    // Idle percentages of the two sides, changed per phase
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // Long receiver hold-offs: the stimulus asks, the receiver serves
    int unsigned hold_asks   = 0;
    int unsigned hold_served = 0;

    int unsigned sent_count = 0;
    int unsigned quiet_cycles = 0;

    logic [BYTE_W-1:0] set_first  [SETTINGS_N];
    logic [BYTE_W-1:0] set_second [SETTINGS_N];

    lbs_cfg_if    cfg_ch();
    lbs_byte_if   byte_ch();
    lbs_result_if res_ch();

    line_break_splitter DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .bytes   (byte_ch),
        .results (res_ch)
    );

    lbs_split_checker u_split_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_ch),
        .bytes      (byte_ch),
        .results    (res_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #2 clk = ~clk;

    // Offer one byte request and hold it until the block takes it.
    // Valid is left high on return, so back-to-back requests need no toggle.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= b;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        sent_count++;
    endtask

    // Drop valid, let every expected result come back, then let any byte
    // that armed a terminator without a result clear the pipeline too.
    task automatic wait_for_drain();
        byte_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write request; valid stays high so writes run back to back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        cfg_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
    endtask

    // Load both terminators while the block is idle, plus a write to a spare index
    task automatic program_breaks(input logic [BYTE_W-1:0] first,
                                  input logic [BYTE_W-1:0] second);
        wait_for_drain();
        write_reg(REG_FIRST_BREAK, first);
        write_reg(REG_SECOND_BREAK, second);
        write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO,
                  8'($urandom_range(0, 255)));
        cfg_ch.valid <= 1'b0;
    endtask

    // A line of random content closed by an ending: in four picks of ten the proper one for
    // the programmed pair, the rest CR/LF pairs, lone CR or LF, broken or doubled endings.
    task automatic send_line(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second);
        logic [BYTE_W-1:0] lead;
        int unsigned       len;
        int unsigned       pick;
        lead = (first != '0) ? first : (($urandom_range(0, 1) != 0) ? CH_CR : CH_LF);
        len  = $urandom_range(0, 6);
        repeat (len) send_byte(8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2, 3:
            begin
                send_byte(lead);
                if (first == '0)
                    send_byte((lead == CH_CR) ? CH_LF : CH_CR);
                else if (second != '0)
                    send_byte(second);
            end
            4:
            begin
                send_byte(CH_CR);
                send_byte(CH_LF);
            end
            5:
            begin
                send_byte(CH_LF);
                send_byte(CH_CR);
            end
            6: send_byte(CH_CR);
            7: send_byte(CH_LF);
            8:
            begin
                send_byte(lead);
                send_byte(8'($urandom_range(0, 255)));
            end
            default:
            begin
                send_byte(lead);
                send_byte(lead);
            end
        endcase
    endtask

    // Receiver: random back-pressure, or a long hold-off when one is asked for
    initial
    begin
        res_ch.ready <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if (hold_asks != hold_served) begin
                hold_served++;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else begin
                res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
                @(posedge clk);
            end
        end
    end

    // Watchdog: count cycles in which no request moves on any channel
    always @(posedge clk)
    begin
        if (rst_n && !(cfg_ch.valid && cfg_ch.ready) && !(byte_ch.valid && byte_ch.ready)
                && !(res_ch.valid && res_ch.ready))
            quiet_cycles <= quiet_cycles + 1;
        else
            quiet_cycles <= 0;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int unsigned base;
        logic        hold_armed;

        byte_ch.valid   <= 1'b0;
        byte_ch.in_byte <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= REG_FIRST_BREAK;
        cfg_ch.data     <= '0;

        // Terminator pairs, one per phase: learning, both orders of CR/LF,
        // single terminators, a preset second with learning, the byte extremes, CR twice and a random pair.
        set_first  = '{8'h00, CH_CR, CH_LF, CH_CR, CH_LF, 8'h00, 8'hFF, 8'h01, CH_CR,
                       8'h00, 8'h00};
        set_second = '{8'h00, CH_LF, CH_CR, 8'h00, 8'h00, CH_LF, 8'h00, 8'hFF, CH_CR,
                       8'hFF, 8'h00};
        set_first[SETTINGS_N-1]  = 8'($urandom_range(1, 255));
        set_second[SETTINGS_N-1] = 8'($urandom_range(1, 255));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 22;
        recv_idle_pct = 71;

        // Directed: out of reset the block learns its terminators.
        // Zero and all-ones bytes are plain content; CR then LF learns a CRLF pair.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h41);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(8'h7F);
        send_byte(8'h80);
        // Wrong second byte: ends the line with a warning, byte comes back as content
        send_byte(CH_CR);
        send_byte(8'h79);
        // Stray LF with nothing before it
        send_byte(CH_LF);
        // CR then CR: the second CR is wrong, then arms the next line; LF closes it
        send_byte(CH_CR);
        send_byte(CH_CR);
        send_byte(CH_LF);
        // Arm with CR, then writes to spare indexes must leave the armed state alone
        send_byte(CH_CR);
        wait_for_drain();
        write_reg(REG_SPARE_LO, 8'hFF);
        write_reg(REG_SPARE_HI, 8'h00);
        cfg_ch.valid <= 1'b0;
        send_byte(CH_LF);

        // Single LF terminator: a CR is stray
        program_breaks(CH_LF, 8'h00);
        send_byte(CH_LF);
        send_byte(CH_CR);
        send_byte(8'h7A);

        // Learning: the same byte twice ends the line, then ends it again as
        // the now known single terminator
        program_breaks(8'h00, 8'h00);
        send_byte(CH_LF);
        send_byte(CH_LF);
        send_byte(CH_CR);

        // Learning: a non line byte after the first terminator comes back as content
        program_breaks(8'h00, 8'h00);
        send_byte(CH_CR);
        send_byte(8'h71);

        // Random phases, one terminator pair each
        for (int k = 0; k < SETTINGS_N; k++) begin
            if (k < 4) begin
                send_idle_pct = 22;
                recv_idle_pct = 71;
            end
            else if (k < 8) begin
                send_idle_pct = 71;
                recv_idle_pct = 22;
            end
            else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            program_breaks(set_first[k], set_second[k]);
            base       = sent_count;
            hold_armed = (k == 1) || (k == 5) || (k == 9);
            while (sent_count - base < BYTES_PER_SET) begin
                // Halfway through, stall the receiver and keep offering bytes
                if (hold_armed && (sent_count - base >= BYTES_PER_SET / 2)) begin
                    hold_asks++;
                    hold_armed = 1'b0;
                end
                send_line(set_first[k], set_second[k]);
            end
        end

        wait_for_drain();
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
